// File: rtl/pse_pkg.sv
// Package for the postfix stack evaluator: data widths, token characters,
// status codes and the default stack depth.
// No dependencies; used by rtl/postfix_stack_evaluator.sv.
package pse_pkg;

	// data path
	localparam int DATA_W     = 32;
	localparam int TOKEN_W    = 8;
	localparam int DEPTH_W    = 5;
	localparam int STATUS_W   = 3;
	localparam int STACK_DEF  = 16;

	// token characters
	localparam logic [TOKEN_W-1:0] TOK_ZERO  = 8'h30;
	localparam logic [TOKEN_W-1:0] TOK_NINE  = 8'h39;
	localparam logic [TOKEN_W-1:0] TOK_ADD   = 8'h2B;
	localparam logic [TOKEN_W-1:0] TOK_SUB   = 8'h2D;
	localparam logic [TOKEN_W-1:0] TOK_MUL   = 8'h2A;
	localparam logic [TOKEN_W-1:0] TOK_DIV   = 8'h2F;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
	localparam logic [STATUS_W-1:0] ST_UNDER = 3'd1;
	localparam logic [STATUS_W-1:0] ST_OVER  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_DIVZ  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_LEFT  = 3'd4;

endpackage

// File: rtl/postfix_stack_evaluator.sv
// Postfix expression evaluator: value stack in a memory, top of stack in a register,
// one shared adder for add, subtract and the divide steps, under a small sequencer.
// Depends on rtl/pse_pkg.sv.
//
// After acceptance a token goes to S_DECODE, then S_FIN for a digit, an error pending or a
// stack that is too short or full; via S_EXEC for + - * unknown characters and divide by zero;
// via S_EXEC, S_DIV (32 divide steps on the shared adder) and S_DIVEND for a division.
// res_valid is registered from S_FIN; no new token is taken before the last is through:
// req_ready is high only while the sequencer is idle, and a held result only stalls S_FIN.
// Reset clears the sequencer, stack depth, sticky status and result valid; the stack memory
// keeps no reset and is only read below the current depth, so no clearing pass is needed.
module postfix_stack_evaluator #(
	parameter int STACK_DEPTH = pse_pkg::STACK_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   req_valid,
	output logic                                   req_ready,
	input  logic [pse_pkg::TOKEN_W-1:0]            token,
	input  logic                                   end_of_expression,
	output logic                                   res_valid,
	input  logic                                   res_ready,
	output logic signed [pse_pkg::DATA_W-1:0]      top_value,
	output logic [pse_pkg::DEPTH_W-1:0]            stack_depth,
	output logic [pse_pkg::STATUS_W-1:0]           status,
	output logic                                   final_res
);
	import pse_pkg::*;

	localparam int DW    = $clog2(STACK_DEPTH + 1);
	localparam int AW    = $clog2(STACK_DEPTH);
	localparam int CNT_W = $clog2(DATA_W);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECODE = 3'd1;
	localparam logic [2:0] S_EXEC   = 3'd2;
	localparam logic [2:0] S_DIV    = 3'd3;
	localparam logic [2:0] S_DIVEND = 3'd4;
	localparam logic [2:0] S_FIN    = 3'd5;

	logic [2:0]              state_q;
	logic [TOKEN_W-1:0]      tok_q;
	logic                    last_q;
	logic [DW-1:0]           depth_q;
	logic [STATUS_W-1:0]     err_q;
	logic [DATA_W-1:0]       top_q;
	logic [DATA_W-1:0]       rd_q;
	logic [DATA_W-1:0]       mem [STACK_DEPTH];

	// divider state
	logic [DATA_W-1:0]       rem_q;
	logic [DATA_W-1:0]       quo_q;
	logic [DATA_W-1:0]       divisor_q;
	logic                    neg_q;
	logic [CNT_W-1:0]        cnt_q;

	// shared adder
	logic [DATA_W:0]         add_x;
	logic [DATA_W:0]         add_y;
	logic                    add_sub;
	logic [DATA_W:0]         add_sum;

	logic                    is_digit;
	logic [DW-1:0]           depth_m1;
	logic [DW-1:0]           depth_m2;
	logic                    out_free;
	logic [DATA_W-1:0]       mag_a;
	logic [DATA_W-1:0]       mag_b;

	assign req_ready = (state_q == S_IDLE);
	assign out_free  = !res_valid || res_ready;
	assign is_digit  = (tok_q >= TOK_ZERO) && (tok_q <= TOK_NINE);
	assign depth_m1  = depth_q - DW'(1);
	assign depth_m2  = depth_q - DW'(2);
	assign mag_a     = rd_q[DATA_W-1] ? (~rd_q + DATA_W'(1)) : rd_q;
	assign mag_b     = top_q[DATA_W-1] ? (~top_q + DATA_W'(1)) : top_q;

	// select adder operands: divide step trial subtract, else older op newer
	always_comb begin
		if (state_q == S_DIV) begin
			add_x   = {rem_q, quo_q[DATA_W-1]};
			add_y   = {1'b0, divisor_q};
			add_sub = 1'b1;
		end else begin
			add_x   = {1'b0, rd_q};
			add_y   = {1'b0, top_q};
			add_sub = (tok_q == TOK_SUB);
		end
		add_sum = add_x + (add_y ^ {(DATA_W+1){add_sub}}) + (DATA_W+1)'(add_sub);
	end

	// stack memory: push the old top below the new one, read the older operand
	always_ff @(posedge clk) begin
		if (state_q == S_DECODE && err_q == ST_OK && is_digit &&
		    depth_q < DW'(STACK_DEPTH) && depth_q != '0) begin
			mem[depth_m1[AW-1:0]] <= top_q;
		end
		rd_q <= mem[depth_m2[AW-1:0]];
	end

	// result valid: raise at the last step, drop on a transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else begin
			priority if (state_q == S_FIN && out_free) begin
				res_valid <= 1'b1;
			end else if (res_ready) begin
				res_valid <= 1'b0;
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			depth_q   <= '0;
			err_q     <= ST_OK;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						tok_q   <= token;
						last_q  <= end_of_expression;
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					if (err_q != ST_OK) begin
						state_q <= S_FIN;
					end else if (is_digit) begin
						state_q <= S_FIN;
						if (depth_q >= DW'(STACK_DEPTH)) begin
							err_q <= ST_OVER;
						end else begin
							top_q   <= DATA_W'(tok_q - TOK_ZERO);
							depth_q <= depth_q + DW'(1);
						end
					end else if (depth_q < DW'(2)) begin
						err_q   <= ST_UNDER;
						state_q <= S_FIN;
					end else begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					priority if (tok_q == TOK_DIV) begin
						if (top_q == '0) begin
							err_q   <= ST_DIVZ;
							state_q <= S_FIN;
						end else begin
							rem_q     <= '0;
							quo_q     <= mag_a;
							divisor_q <= mag_b;
							neg_q     <= rd_q[DATA_W-1] ^ top_q[DATA_W-1];
							cnt_q     <= '0;
							state_q   <= S_DIV;
						end
					end else if (tok_q == TOK_ADD || tok_q == TOK_SUB) begin
						top_q   <= add_sum[DATA_W-1:0];
						depth_q <= depth_m1;
						state_q <= S_FIN;
					end else if (tok_q == TOK_MUL) begin
						top_q   <= rd_q * top_q;
						depth_q <= depth_m1;
						state_q <= S_FIN;
					end else begin
						// unknown character keeps the newer value
						depth_q <= depth_m1;
						state_q <= S_FIN;
					end
				end
				S_DIV: begin
					// one restoring step per cycle
					if (!add_sum[DATA_W]) begin
						rem_q <= add_sum[DATA_W-1:0];
						quo_q <= {quo_q[DATA_W-2:0], 1'b1};
					end else begin
						rem_q <= {rem_q[DATA_W-2:0], quo_q[DATA_W-1]};
						quo_q <= {quo_q[DATA_W-2:0], 1'b0};
					end
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(DATA_W - 1)) begin
						state_q <= S_DIVEND;
					end
				end
				S_DIVEND: begin
					top_q   <= neg_q ? (~quo_q + DATA_W'(1)) : quo_q;
					depth_q <= depth_m1;
					state_q <= S_FIN;
				end
				S_FIN: begin
					// hold until the result register frees up
					if (out_free) begin
						final_res <= last_q;
						state_q   <= S_IDLE;
						if (last_q) begin
							stack_depth <= '0;
							depth_q     <= '0;
							err_q       <= ST_OK;
							if (err_q != ST_OK) begin
								top_value <= '0;
								status    <= err_q;
							end else if (depth_q == '0) begin
								top_value <= '0;
								status    <= ST_UNDER;
							end else begin
								top_value <= top_q;
								status    <= (depth_q != DW'(1)) ? ST_LEFT : ST_OK;
							end
						end else begin
							stack_depth <= DEPTH_W'(depth_q);
							status      <= err_q;
							top_value   <= (err_q == ST_OK && depth_q != '0) ? top_q : '0;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// File: verif/postfix_stack_evaluator_tb.sv
// Self-checking testbench for postfix_stack_evaluator: drives tokens and checks every result
// against a stack predictor held in a small scoreboard class.
// Depends on rtl/pse_pkg.sv and rtl/postfix_stack_evaluator.sv.
module postfix_stack_evaluator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pse_pkg::*;

	localparam int CLK_PERIOD      = 4;
	localparam int ITEMS_PER_PHASE = 160;
	localparam int CYCLE_LIMIT     = 400000;
	localparam int SETTLE_CYCLES   = 60;
	localparam int MAX_REPORTS     = 10;

	typedef struct packed {
		logic signed [DATA_W-1:0] top;
		logic [DEPTH_W-1:0]       depth;
		logic [STATUS_W-1:0]      code;
		logic                     fin;
	} eval_result_t;

	// Stack predictor plus the queue of results it has worked out
	class rpn_scoreboard;
		logic [DATA_W-1:0]   values [STACK_DEF];
		int                  depth;
		logic [STATUS_W-1:0] sticky;
		eval_result_t        pending_results[$];
		int                  mismatches;

		function new();
			depth      = 0;
			sticky     = ST_OK;
			mismatches = 0;
		endfunction

		// Divide on magnitudes, then restore the sign (truncates toward zero)
		function logic [DATA_W-1:0] trunc_quot(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
			logic [DATA_W-1:0] ma, mb, q;
			ma = a[DATA_W-1] ? -a : a;
			mb = b[DATA_W-1] ? -b : b;
			q  = ma / mb;
			return (a[DATA_W-1] ^ b[DATA_W-1]) ? -q : q;
		endfunction

		// Push a digit or reduce the top two values; flag errors without touching the stack
		function void push_or_reduce(logic [TOKEN_W-1:0] tok);
			logic [DATA_W-1:0] a, b, r;
			if (tok >= TOK_ZERO && tok <= TOK_NINE) begin
				if (depth >= STACK_DEF) begin
					sticky = ST_OVER;
					return;
				end
				values[depth] = DATA_W'(tok - TOK_ZERO);
				depth++;
				return;
			end
			if (depth < 2) begin
				sticky = ST_UNDER;
				return;
			end
			b = values[depth-1];
			a = values[depth-2];
			case (tok)
				TOK_ADD: r = a + b;
				TOK_SUB: r = a - b;
				TOK_MUL: r = a * b;
				TOK_DIV: begin
					if (b == '0) begin
						sticky = ST_DIVZ;
						return;
					end
					r = trunc_quot(a, b);
				end
				// unknown character keeps the newer value only
				default: r = b;
			endcase
			values[depth-2] = r;
			depth--;
		endfunction

		// Advance the predictor by one accepted token and queue its result
		function void note_token(logic [TOKEN_W-1:0] tok, logic eoe);
			eval_result_t r;
			r = '0;
			if (sticky == ST_OK)
				push_or_reduce(tok);
			if (eoe) begin
				if (sticky == ST_OK) begin
					if (depth == 0) begin
						sticky = ST_UNDER;
					end else begin
						depth--;
						r.top = values[depth];
						if (depth != 0)
							sticky = ST_LEFT;
					end
				end
				r.code = sticky;
				r.depth = '0;
				depth = 0;
				sticky = ST_OK;
			end else begin
				if (sticky == ST_OK && depth > 0)
					r.top = values[depth-1];
				r.code = sticky;
				r.depth = DEPTH_W'(depth);
			end
			r.fin = eoe;
			pending_results.push_back(r);
		endfunction

		// Compare one transfer from the block with the oldest prediction
		function void check_result(eval_result_t got);
			eval_result_t want;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected result: top=%0d depth=%0d status=%0d final=%0b",
						got.top, got.depth, got.code, got.fin);
				return;
			end
			want = pending_results.pop_front();
			if (got.top !== want.top || got.depth !== want.depth ||
					got.code !== want.code || got.fin !== want.fin) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("mismatch at %0t (exp/act): top %0d/%0d depth %0d/%0d",
						$realtime, want.top, got.top, want.depth, got.depth,
						" status %0d/%0d final %0b/%0b",
						want.code, got.code, want.fin, got.fin);
			end
		endfunction

		function int outstanding();
			return pending_results.size();
		endfunction
	endclass

	logic                       clk;
	logic                       arst_n;
	logic                       req_valid;
	logic                       req_ready;
	logic [TOKEN_W-1:0]         token;
	logic                       end_of_expression;
	logic                       res_valid;
	logic                       res_ready;
	logic signed [DATA_W-1:0]   top_value;
	logic [DEPTH_W-1:0]         stack_depth;
	logic [STATUS_W-1:0]        status;
	logic                       final_res;

	rpn_scoreboard      sb = new();
	logic [TOKEN_W-1:0] expr_q[$];
	int                 send_idle_pct;
	int                 recv_stall_pct;
	int                 items_sent;
	int                 cycle_count;

	postfix_stack_evaluator dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.req_valid         (req_valid),
		.req_ready         (req_ready),
		.token             (token),
		.end_of_expression (end_of_expression),
		.res_valid         (res_valid),
		.res_ready         (res_ready),
		.top_value         (top_value),
		.stack_depth       (stack_depth),
		.status            (status),
		.final_res         (final_res)
	);

	initial clk = 1'b0;
	always #(CLK_PERIOD/2) clk = ~clk;

	// Check each result transfer, then pick the next ready level
	always @(posedge clk) begin
		if (res_valid && res_ready)
			sb.check_result('{top: top_value, depth: stack_depth, code: status, fin: final_res});
		res_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Offer one token, with an optional random gap first, and hold it until the transfer
	task automatic send_token(input logic [TOKEN_W-1:0] tok, input logic eoe);
		if ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(posedge clk);
		end
		req_valid <= 1'b1;
		token <= tok;
		end_of_expression <= eoe;
		do @(posedge clk); while (!req_ready);
		sb.note_token(tok, eoe);
		items_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_token(s[i], i == s.len() - 1);
	endtask

	task automatic send_expr_q();
		for (int i = 0; i < expr_q.size(); i++)
			send_token(expr_q[i], i == expr_q.size() - 1);
	endtask

	// Hold off the sender until every predicted result has come back
	task automatic drain();
		req_valid <= 1'b0;
		while (sb.outstanding() != 0)
			@(posedge clk);
	endtask

	function automatic logic [TOKEN_W-1:0] pick_op();
		logic [TOKEN_W-1:0] c;
		if ($urandom_range(9) == 0) begin
			do c = TOKEN_W'($urandom_range(255)); while (c >= TOK_ZERO && c <= TOK_NINE);
			return c;
		end
		case ($urandom_range(3))
			0:       return TOK_ADD;
			1:       return TOK_SUB;
			2:       return TOK_MUL;
			default: return TOK_DIV;
		endcase
	endfunction

	function automatic logic [TOKEN_W-1:0] pick_digit();
		return TOKEN_W'(TOK_ZERO + $urandom_range(9));
	endfunction

	// Build a valid expression: mostly shallow, now and then up to the full stack
	function automatic void make_wellformed();
		int d, pushes, cap;
		expr_q.delete();
		d = 0;
		cap = ($urandom_range(9) == 0) ? STACK_DEF : $urandom_range(2, 6);
		pushes = $urandom_range(1, ($urandom_range(9) == 0) ? 24 : 8);
		while (pushes > 0 || d > 1) begin
			if (pushes > 0 && (d < 2 || (d < cap && $urandom_range(1) == 1))) begin
				expr_q.push_back(pick_digit());
				pushes--;
				d++;
			end else begin
				expr_q.push_back(pick_op());
				d--;
			end
		end
	endfunction

	function automatic void make_noise();
		expr_q.delete();
		repeat ($urandom_range(1, 10))
			expr_q.push_back(TOKEN_W'($urandom_range(255)));
	endfunction

	// Corrupt a valid expression: leftovers, stray bytes, early operator or overflow
	function automatic void make_broken();
		make_wellformed();
		case ($urandom_range(3))
			0: if (expr_q.size() > 1) void'(expr_q.pop_back());
			1: expr_q.insert($urandom_range(expr_q.size() - 1), TOKEN_W'($urandom_range(255)));
			2: expr_q.push_front(pick_op());
			default: repeat (STACK_DEF + 1) expr_q.push_front(pick_digit());
		endcase
	endfunction

	// Long sequences: overflow, full stack, most negative over minus one, most positive
	task automatic run_corners();
		send_text("99999999999999999+");
		send_text("9999999999999999+++++++++++++++");
		send_text("88888888882**********01-/");
		send_text("88888888882**********1-");
	endtask

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		token = '0;
		end_of_expression = 1'b0;
		res_ready = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		items_sent = 0;
		cycle_count = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: basic ops, sticky underflow, divide by zero, leftovers, unknown byte
		send_text("34+");
		send_token(8'h00, 1'b0);
		send_token(TOK_NINE, 1'b0);
		send_token(8'hFF, 1'b1);
		send_text("95-7*2/");
		send_text("50/");
		send_text("12");
		send_text("+");
		send_token(TOK_ZERO, 1'b0);
		send_token(TOK_NINE, 1'b0);
		send_token(8'hFF, 1'b1);
		send_text("07-2/");
		drain();

		// random phases: none, sender idle, receiver stall, both
		for (int phase = 0; phase < 4; phase++) begin
			int phase_start;
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
				default: begin send_idle_pct = 31; recv_stall_pct = 31; end
			endcase
			run_corners();
			phase_start = items_sent;
			while (items_sent - phase_start < ITEMS_PER_PHASE) begin
				int pick;
				pick = $urandom_range(99);
				if (pick < 70)
					make_wellformed();
				else if (pick < 85)
					make_noise();
				else
					make_broken();
				send_expr_q();
			end
			drain();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.outstanding() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// File: filelist.f
rtl/pse_pkg.sv
rtl/postfix_stack_evaluator.sv
verif/postfix_stack_evaluator_tb.sv
